// ----- src/bresenham_line_stepper_top_defines.svh -----
// Assertion macros used by the line stepper back end.
`ifndef BRESENHAM_LINE_STEPPER_TOP_DEFINES_SVH
`define BRESENHAM_LINE_STEPPER_TOP_DEFINES_SVH

`ifndef SYNTH
`define BLS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bls: assertion failed");
`define BLS_ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("bls: assertion failed");
`else
`define BLS_ASSERT(lbl, clk, rst, prop)
`define BLS_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif

`endif

// ----- src/bls_pkg.sv -----
// Shared constants and helpers for the line stepper.
package bls_pkg;

  localparam int DEF_COORD_BITS = 12;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  // start flag, four coordinates, two flags, three decision words, pixel count
  function automatic int entry_bits(input int cb);
    return 8 * cb + 13;
  endfunction

endpackage

// ----- src/bls_intf.sv -----
// Request and pixel channel interfaces of the line stepper.
interface bls_req_if #(parameter int COORD_BITS = bls_pkg::DEF_COORD_BITS);
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (output valid, action, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, action, start_x, start_y, end_x, end_y, output ready);
endinterface

interface bls_pix_if #(parameter int COORD_BITS = bls_pkg::DEF_COORD_BITS);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic                         last_pixel;

  modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

// ----- src/bls_front.sv -----
// Front end: accepts requests, orders endpoints and sets up the decision terms.
module bls_front #(
  parameter int COORD_BITS = bls_pkg::DEF_COORD_BITS
) (
  input  logic                                          clk,
  input  logic                                          rst,
  bls_req_if.sink                                       req,
  output logic                                          q_valid,
  input  logic                                          q_ready,
  output logic [bls_pkg::entry_bits(COORD_BITS)-1:0]    q_data
);
  import bls_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int DW = CB + 3;

  typedef struct packed {
    logic                 start;
    logic signed [CB-1:0] cur_x;
    logic signed [CB-1:0] cur_y;
    logic signed [CB-1:0] fin_x;
    logic signed [CB-1:0] fin_y;
    logic                 is_wide;
    logic                 slope_up;
    logic signed [DW-1:0] decision;
    logic signed [DW-1:0] inc_straight;
    logic signed [DW-1:0] inc_diagonal;
    logic [CB:0]          remaining;
  } entry_t;

  logic                 a_valid;
  logic                 a_action;
  logic signed [CB-1:0] a_x0, a_y0, a_x1, a_y1;
  logic [CB-1:0]        a_dx, a_ady;
  logic                 a_up;
  logic                 a_ready;

  logic                 swap;
  logic signed [CB-1:0] x0, y0, x1, y1;
  logic [CB:0]          dx_full, dyp, dyn;

  logic                 wide;
  logic [CB-1:0]        major, minor;
  entry_t               ent;

  assign swap    = req.start_x > req.end_x;
  assign x0      = swap ? req.end_x   : req.start_x;
  assign y0      = swap ? req.end_y   : req.start_y;
  assign x1      = swap ? req.start_x : req.end_x;
  assign y1      = swap ? req.start_y : req.end_y;
  assign dx_full = {x1[CB-1], x1} - {x0[CB-1], x0};
  assign dyp     = {y1[CB-1], y1} - {y0[CB-1], y0};
  assign dyn     = {y0[CB-1], y0} - {y1[CB-1], y1};

  assign a_ready   = !a_valid || q_ready;
  assign req.ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= req.valid;
    end
    if (a_ready && req.valid) begin
      a_action <= req.action;
      a_x0     <= x0;
      a_y0     <= y0;
      a_x1     <= x1;
      a_y1     <= y1;
      a_dx     <= dx_full[CB-1:0];
      a_up     <= !dyp[CB];
      a_ady    <= dyp[CB] ? dyn[CB-1:0] : dyp[CB-1:0];
    end
  end

  assign wide  = a_dx >= a_ady;
  assign major = wide ? a_dx : a_ady;
  assign minor = wide ? a_ady : a_dx;

  always_comb begin
    ent              = '0;
    ent.start        = (a_action == ACT_START);
    ent.cur_x        = a_x0;
    ent.cur_y        = a_y0;
    ent.fin_x        = a_x1;
    ent.fin_y        = a_y1;
    ent.is_wide      = wide;
    ent.slope_up     = a_up;
    ent.decision     = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
    ent.inc_straight = $signed({2'b00, minor, 1'b0});
    ent.inc_diagonal = $signed({2'b00, minor, 1'b0}) - $signed({2'b00, major, 1'b0});
    ent.remaining    = {1'b0, major} + {{CB{1'b0}}, 1'b1};
  end

  assign q_valid = a_valid;
  assign q_data  = ent;
endmodule

// ----- src/bls_queue.sv -----
// Small register FIFO between the front end and the stepper.
module bls_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = bls_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;
  logic             push, pop;

  assign in_ready  = count != CW'(DEPTH);
  assign out_valid = count != '0;
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end
endmodule

// ----- src/bls_back.sv -----
// Back end: holds the active line, steps the decision value and registers pixels.
`include "bresenham_line_stepper_top_defines.svh"

module bls_back #(
  parameter int COORD_BITS = bls_pkg::DEF_COORD_BITS
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       q_valid,
  output logic                                       q_ready,
  input  logic [bls_pkg::entry_bits(COORD_BITS)-1:0] q_data,
  bls_pix_if.source                                  pix
);
  import bls_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int DW = CB + 3;

  typedef struct packed {
    logic                 start;
    logic signed [CB-1:0] cur_x;
    logic signed [CB-1:0] cur_y;
    logic signed [CB-1:0] fin_x;
    logic signed [CB-1:0] fin_y;
    logic                 is_wide;
    logic                 slope_up;
    logic signed [DW-1:0] decision;
    logic signed [DW-1:0] inc_straight;
    logic signed [DW-1:0] inc_diagonal;
    logic [CB:0]          remaining;
  } entry_t;

  entry_t               head;
  logic                 active;
  logic signed [CB-1:0] cur_x, cur_y, final_x, final_y;
  logic signed [DW-1:0] decision, inc_straight, inc_diagonal;
  logic [CB:0]          remaining;
  logic                 is_wide, slope_up;

  logic                 ov;
  logic signed [CB-1:0] px, py;
  logic                 plast;

  logic                 out_free, take, pop, emit;
  logic [CB-1:0]        ystep;

  assign head     = entry_t'(q_data);
  assign out_free = !ov || pix.ready;
  assign take     = head.start || !active || out_free;
  assign q_ready  = take;
  assign pop      = q_valid && take;
  assign emit     = pop && !head.start && active;
  assign ystep    = slope_up ? CB'(1) : '1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      remaining <= '0;
      ov        <= 1'b0;
    end else begin
      if (emit) begin
        ov <= 1'b1;
      end else if (pix.ready) begin
        ov <= 1'b0;
      end
      if (pop && head.start) begin
        active       <= 1'b1;
        cur_x        <= head.cur_x;
        cur_y        <= head.cur_y;
        final_x      <= head.fin_x;
        final_y      <= head.fin_y;
        is_wide      <= head.is_wide;
        slope_up     <= head.slope_up;
        decision     <= head.decision;
        inc_straight <= head.inc_straight;
        inc_diagonal <= head.inc_diagonal;
        remaining    <= head.remaining;
      end else if (emit) begin
        if (remaining <= (CB+1)'(1)) begin
          px        <= final_x;
          py        <= final_y;
          plast     <= 1'b1;
          cur_x     <= final_x;
          cur_y     <= final_y;
          remaining <= '0;
          active    <= 1'b0;
        end else begin
          px        <= cur_x;
          py        <= cur_y;
          plast     <= 1'b0;
          remaining <= remaining - (CB+1)'(1);
          if (decision > 0) begin
            cur_x    <= cur_x + CB'(1);
            cur_y    <= cur_y + ystep;
            decision <= decision + inc_diagonal;
          end else begin
            if (is_wide) begin
              cur_x <= cur_x + CB'(1);
            end else begin
              cur_y <= cur_y + ystep;
            end
            decision <= decision + inc_straight;
          end
        end
      end
    end
  end

  assign pix.valid      = ov;
  assign pix.pixel_x    = px;
  assign pix.pixel_y    = py;
  assign pix.last_pixel = plast;

  `BLS_ASSERT(a_active_count, clk, rst, active == (remaining != '0))
  `BLS_ASSERT_NEXT(a_start_arms, clk, rst, pop && head.start, active)
  `BLS_ASSERT_NEXT(a_wide_step, clk, rst, emit && is_wide && remaining > (CB+1)'(1), cur_x == $past(cur_x) + CB'(1))
endmodule

// ----- src/bresenham_line_stepper_top.sv -----
// Line stepper: Bresenham rasterizer top level with request and pixel channels.
//
// req channel: action 0 is a start request carrying both endpoints; it loads a
// new line, abandons any line in progress and yields no pixel. action 1 is a
// step request; it yields the next pixel of the active line, or nothing when no
// line is active. A line of major delta d yields d+1 pixels; the last one is
// the exact right endpoint with last_pixel set.
// pix channel: pixel_x, pixel_y, last_pixel, valid/ready.
// A step request passes the setup register, queue and pixel register before
// its pixel shows. Throughput is one request per cycle while pix.ready is high,
// set by the single add and compare of the decision loop in the stepper.
// Reset (rst, synchronous): no line active, queue and pixel register empty.
// When pix.ready is low the pixel register holds; the queue keeps taking
// requests until it fills, then req.ready drops. Start requests and steps on an
// idle stepper drain from the queue even while the pixel side stalls.
module bresenham_line_stepper_top #(
  parameter int COORD_BITS = bls_pkg::DEF_COORD_BITS
) (
  input  logic      clk,
  input  logic      rst,
  bls_req_if.sink   req,
  bls_pix_if.source pix
);
  import bls_pkg::*;

  localparam int EW = entry_bits(COORD_BITS);

  logic          fq_valid, fq_ready;
  logic [EW-1:0] fq_data;
  logic          qb_valid, qb_ready;
  logic [EW-1:0] qb_data;

  bls_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_valid (fq_valid),
    .q_ready (fq_ready),
    .q_data  (fq_data)
  );

  bls_queue #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_data  (qb_data)
  );

  bls_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (qb_valid),
    .q_ready (qb_ready),
    .q_data  (qb_data),
    .pix     (pix)
  );
endmodule
